@@ rtl/pmc_pkg.sv @@
// Package for the panel menu controller: codes, register indexes, types and the menu table.
`default_nettype none
package pmc_pkg;

   // Cursor positions in each menu (2 to 4)
   localparam int MENU_ENTRIES = 4;

   localparam int TIMER_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_MS        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_LEAD_MS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPLASH_MS      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MESSAGE_MS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCH_HOLD_MS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REDRAW_MS      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_LEVEL      = 3'd6;

   localparam logic [TIMER_W-1:0] HOLD_MS_RESET        = 16'd15000;
   localparam logic [TIMER_W-1:0] DIM_LEAD_MS_RESET    = 16'd5000;
   localparam logic [TIMER_W-1:0] SPLASH_MS_RESET      = 16'd1000;
   localparam logic [TIMER_W-1:0] MESSAGE_MS_RESET     = 16'd2000;
   localparam logic [TIMER_W-1:0] SWITCH_HOLD_MS_RESET = 16'd2000;
   localparam logic [TIMER_W-1:0] REDRAW_MS_RESET      = 16'd300;
   localparam logic [7:0]         DIM_LEVEL_RESET      = 8'h10;

   localparam logic [7:0] CONTRAST_BRIGHT = 8'hFF;
   localparam logic [7:0] CONTRAST_OFF    = 8'h00;

   // Previous battery value after reset, never a real state, so the first tick redraws
   localparam logic [3:0] BATT_NONE = 4'd15;

   typedef enum logic [2:0] {
      MODE_STARTUP = 3'd0,
      MODE_MESSAGE = 3'd1,
      MODE_SPLASH  = 3'd2,
      MODE_SCREEN  = 3'd3,
      MODE_MENU    = 3'd4,
      MODE_ACTION  = 3'd5,
      MODE_OFF     = 3'd6
   } mode_type;

   typedef enum logic [3:0] {
      BATT_UNINIT       = 4'd0,
      BATT_DISCONNECTED = 4'd1,
      BATT_REMOVED      = 4'd2,
      BATT_SHUTDOWN     = 4'd3,
      BATT_INIT         = 4'd4,
      BATT_XDSG         = 4'd5,
      BATT_DSG          = 4'd6,
      BATT_CHG          = 4'd7,
      BATT_PF           = 4'd8,
      BATT_PWRCYCLE     = 4'd9,
      BATT_LATCHED      = 4'd10
   } batt_type;

   typedef struct packed {
      logic [TIMER_W-1:0] hold_ms;
      logic [TIMER_W-1:0] dim_lead_ms;
      logic [TIMER_W-1:0] splash_ms;
      logic [TIMER_W-1:0] message_ms;
      logic [TIMER_W-1:0] switch_hold_ms;
      logic [TIMER_W-1:0] redraw_ms;
      logic [7:0]         dim_level;
   } cfg_type;

   typedef struct packed {
      mode_type           mode;
      logic [3:0]         view;
      logic [1:0]         cursor;
      logic [3:0]         prev_battery;
      logic               prev_switch;
      logic               press_armed;
      logic [TIMER_W-1:0] press_left;
      logic [TIMER_W-1:0] phase_left;
      logic               phase_forever;
      logic [TIMER_W-1:0] refresh_left;
      logic [7:0]         written_contrast;
   } state_type;

   typedef struct packed {
      logic [2:0] display_mode;
      logic [3:0] view_id;
      logic [1:0] selected_entry;
      logic [7:0] contrast;
      logic       contrast_write;
      logic       panel_on_cmd;
      logic       panel_off_cmd;
      logic       redraw;
   } result_type;

   typedef struct packed {
      mode_type   mode;
      logic [3:0] view;
   } target_type;

   // Fixed two-menu table: main menu (0) and more menu (1)
   function automatic target_type menu_lookup(input logic menu, input logic [1:0] entry);
      target_type t;
      t.mode = MODE_SCREEN;
      t.view = 4'd0;
      case ({menu, entry})
         3'b000: begin t.mode = MODE_SCREEN; t.view = 4'd0; end
         3'b001: begin t.mode = MODE_SCREEN; t.view = 4'd1; end
         3'b010: begin t.mode = MODE_SCREEN; t.view = 4'd2; end
         3'b011: begin t.mode = MODE_MENU;   t.view = 4'd1; end
         3'b100: begin t.mode = MODE_SCREEN; t.view = 4'd3; end
         3'b101: begin t.mode = MODE_SCREEN; t.view = 4'd4; end
         3'b110: begin t.mode = MODE_ACTION; t.view = 4'd0; end
         default: begin t.mode = MODE_MENU;  t.view = 4'd0; end
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

@@ rtl/pmc_config.sv @@
// Configuration register file of the panel menu controller.
`default_nettype none
module pmc_config (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_write_enable,
   input  wire  [pmc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [pmc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output pmc_pkg::cfg_type                   cfg
);
   import pmc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HOLD_MS:        cfg_in.hold_ms        = csr_write_data;
            CSR_DIM_LEAD_MS:    cfg_in.dim_lead_ms    = csr_write_data;
            CSR_SPLASH_MS:      cfg_in.splash_ms      = csr_write_data;
            CSR_MESSAGE_MS:     cfg_in.message_ms     = csr_write_data;
            CSR_SWITCH_HOLD_MS: cfg_in.switch_hold_ms = csr_write_data;
            CSR_REDRAW_MS:      cfg_in.redraw_ms      = csr_write_data;
            CSR_DIM_LEVEL:      cfg_in.dim_level      = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ms        <= HOLD_MS_RESET;
         cfg_ff.dim_lead_ms    <= DIM_LEAD_MS_RESET;
         cfg_ff.splash_ms      <= SPLASH_MS_RESET;
         cfg_ff.message_ms     <= MESSAGE_MS_RESET;
         cfg_ff.switch_hold_ms <= SWITCH_HOLD_MS_RESET;
         cfg_ff.redraw_ms      <= REDRAW_MS_RESET;
         cfg_ff.dim_level      <= DIM_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ rtl/pmc_step.sv @@
// Per-tick decision logic: next controller state and the result item from one sample.
`default_nettype none
module pmc_step (
   input  pmc_pkg::cfg_type     cfg,
   input  pmc_pkg::state_type   st,
   input  wire                  switch_level,
   input  wire  [3:0]           batt_status,
   input  wire                  safety_fault,
   input  wire                  message_pending,
   output pmc_pkg::state_type   st_next,
   output pmc_pkg::result_type  res
);
   import pmc_pkg::*;

   logic [TIMER_W-1:0] press_left;
   logic [TIMER_W-1:0] phase_left;
   logic               phase_forever;
   logic [TIMER_W-1:0] refresh_left;
   logic               press_armed;
   logic               dim, tap, hold, stale_press, show_def, reached, trans, due;
   logic               redraw, off_cmd;
   logic [3:0]         batt;
   mode_type           t_mode;
   logic [3:0]         t_view;
   logic [1:0]         new_cursor;
   logic [2:0]         cursor_sum;
   logic [7:0]         target_c;
   target_type         entry;

   always_comb begin
      // saturating countdowns
      press_left   = (st.press_left != '0) ? st.press_left - 1'b1 : st.press_left;
      phase_left   = (!st.phase_forever && st.phase_left != '0) ?
                     st.phase_left - 1'b1 : st.phase_left;
      phase_forever = st.phase_forever;
      refresh_left = (st.refresh_left != '0) ? st.refresh_left - 1'b1 : st.refresh_left;

      t_mode     = st.mode;
      t_view     = st.view;
      new_cursor = st.cursor;
      redraw     = 1'b0;
      off_cmd    = 1'b0;

      dim = (st.mode == MODE_MENU || st.mode == MODE_SCREEN) && !phase_forever &&
            (phase_left < cfg.dim_lead_ms);

      // tap / hold detection
      tap         = 1'b0;
      hold        = 1'b0;
      stale_press = 1'b0;
      press_armed = st.press_armed;
      if (switch_level != st.prev_switch) begin
         stale_press = !press_armed || press_left == '0;
         tap         = !switch_level && !stale_press;
         press_armed = 1'b1;
         press_left  = cfg.switch_hold_ms;
      end
      if (press_armed && press_left == '0) begin
         hold        = switch_level;
         press_armed = 1'b0;
      end

      // a tap on a screen or menu restarts its lifetime
      if (tap && (st.mode == MODE_SCREEN || st.mode == MODE_MENU)) begin
         phase_left    = cfg.hold_ms;
         phase_forever = 1'b0;
      end

      reached  = !phase_forever && phase_left == '0;
      batt     = batt_status;
      show_def = (st.prev_battery != batt_status);
      // splash holds on and ignores battery changes until it runs out
      if (st.mode == MODE_SPLASH && !reached) begin
         show_def = 1'b0;
         batt     = st.prev_battery;
      end

      if (reached) begin
         if (st.mode == MODE_STARTUP) t_mode = MODE_SPLASH;
         else if (st.mode == MODE_SPLASH || st.mode == MODE_MESSAGE) show_def = 1'b1;
         else t_mode = MODE_OFF;
      end

      cursor_sum = {1'b0, st.cursor} + 3'd1;
      if (tap) begin
         case (st.mode)
            MODE_MENU: begin
               new_cursor = (cursor_sum >= 3'(MENU_ENTRIES)) ?
                            2'(cursor_sum - 3'(MENU_ENTRIES)) : cursor_sum[1:0];
            end
            MODE_SCREEN: begin
               if (!dim) begin
                  if (st.view <= 4'd2 || st.view == 4'd10) begin
                     t_mode = MODE_MENU; t_view = 4'd0;
                  end else if (st.view == 4'd3 || st.view == 4'd4) begin
                     t_mode = MODE_MENU; t_view = 4'd1;
                  end
               end else begin
                  dim = 1'b0;      // tap on a dimmed screen only wakes it
               end
            end
            MODE_OFF: show_def = 1'b1;
            default: ;
         endcase
      end

      entry = menu_lookup(st.view[0], st.cursor);
      if (hold) begin
         if (st.mode == MODE_MENU) begin
            t_mode = entry.mode;
            t_view = entry.view;
         end else if (st.mode == MODE_OFF) begin
            show_def = 1'b1;
         end
      end

      // battery state to default screen; unmapped codes choose nothing
      if (show_def) begin
         case (batt)
            BATT_UNINIT:       t_mode = MODE_SPLASH;
            BATT_DISCONNECTED: begin t_mode = MODE_SCREEN; t_view = 4'd5; end
            BATT_SHUTDOWN:     begin t_mode = MODE_SCREEN; t_view = 4'd8; end
            BATT_INIT:         begin t_mode = MODE_SCREEN; t_view = 4'd6; end
            BATT_PF:           begin t_mode = MODE_SCREEN; t_view = 4'd7; end
            BATT_PWRCYCLE:     begin t_mode = MODE_SCREEN; t_view = 4'd9; end
            BATT_XDSG:         begin t_mode = MODE_SCREEN; t_view = 4'd10; end
            BATT_REMOVED, BATT_DSG, BATT_CHG, BATT_LATCHED: begin
               t_mode = MODE_SCREEN;
               t_view = safety_fault ? 4'd2 : 4'd0;
            end
            default: ;
         endcase
      end

      if (message_pending) t_mode = MODE_MESSAGE;

      trans = (t_mode != st.mode);
      if (!trans && (t_mode == MODE_SCREEN || t_mode == MODE_MENU || t_mode == MODE_ACTION))
         trans = (t_view != st.view);

      due = (refresh_left == '0) || trans || (new_cursor != st.cursor);

      target_c = (t_mode == MODE_OFF) ? CONTRAST_OFF : CONTRAST_BRIGHT;
      if (!trans && dim) target_c = cfg.dim_level;

      if (due) begin
         case (t_mode)
            MODE_SPLASH: begin
               if (trans) begin
                  phase_left = cfg.splash_ms; phase_forever = 1'b0; redraw = 1'b1;
               end
            end
            MODE_MESSAGE: begin
               if (trans) begin
                  phase_left = cfg.message_ms; phase_forever = 1'b0;
               end
            end
            MODE_SCREEN, MODE_ACTION: begin
               if (trans) begin
                  phase_left = cfg.hold_ms; phase_forever = 1'b0;
               end
               redraw = 1'b1;
            end
            MODE_MENU: begin
               if (trans) begin
                  new_cursor = 2'd0;
                  phase_left = cfg.hold_ms; phase_forever = 1'b0;
               end
               redraw = 1'b1;
            end
            default: begin
               if (trans) begin
                  phase_left = '0; phase_forever = 1'b1; off_cmd = 1'b1;
               end
            end
         endcase
         refresh_left = cfg.redraw_ms;
      end

      st_next.mode             = t_mode;
      st_next.view             = t_view;
      st_next.cursor           = new_cursor;
      st_next.prev_battery     = batt;
      st_next.prev_switch      = switch_level;
      st_next.press_armed      = press_armed;
      st_next.press_left       = press_left;
      st_next.phase_left       = phase_left;
      st_next.phase_forever    = phase_forever;
      st_next.refresh_left     = refresh_left;
      st_next.written_contrast = target_c;

      res.display_mode   = t_mode;
      res.view_id        = (t_mode == MODE_SCREEN || t_mode == MODE_MENU ||
                            t_mode == MODE_ACTION) ? t_view : 4'd0;
      res.selected_entry = (t_mode == MODE_MENU) ? new_cursor : 2'd0;
      res.contrast       = target_c;
      res.contrast_write = (st.written_contrast != target_c);
      res.panel_on_cmd   = trans && st.mode == MODE_OFF;
      res.panel_off_cmd  = off_cmd;
      res.redraw         = redraw;
   end

endmodule
`default_nettype wire

@@ rtl/panel_menu_controller.sv @@
// Top level of the one-button front-panel controller.
//
// Use: send one sample per millisecond tick on the req_ channel (button level,
// battery state, safety fault, message request). Each sample yields exactly one
// result on the rsp_ channel: display mode, view, menu cursor, contrast and the
// contrast-write, panel-on, panel-off and redraw pulses.
// Transfers happen on a rising edge with valid high and stall low.
// Path: a transferred sample is registered in the input stage, and its result
// is then registered in the result register, which drives rsp_valid.
// Throughput: one sample per cycle while the receiver does not stall, set by the
// combinational decision logic between the input register and the result register.
// Receiver stall: the result register holds; the input stage keeps one more
// sample, then req_stall rises until the result is taken.
// Reset (synchronous): controller state returns to startup with all timers
// expired; configuration registers return to their defaults. The csr_ port
// writes one register per enabled edge and should only be used while idle.
`default_nettype none
module panel_menu_controller (
   input  wire                              clock,
   input  wire                              reset,
   // sample channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_switch_level,
   input  wire  [3:0]                       req_batt_status,
   input  wire                              req_safety_fault,
   input  wire                              req_message_pending,
   // result channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [2:0]                       rsp_display_mode,
   output logic [3:0]                       rsp_view_id,
   output logic [1:0]                       rsp_selected_entry,
   output logic [7:0]                       rsp_contrast,
   output logic                             rsp_contrast_write,
   output logic                             rsp_panel_on_cmd,
   output logic                             rsp_panel_off_cmd,
   output logic                             rsp_redraw,
   // configuration writes
   input  wire                              csr_write_enable,
   input  wire  [pmc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [pmc_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import pmc_pkg::*;

   cfg_type    cfg;

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_switch_ff;
   logic [3:0] s1_battery_ff;
   logic       s1_fault_ff;
   logic       s1_message_ff;

   // controller state and result register
   state_type  state_ff, state_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       advance;   // input stage moves into the result register
   logic       req_take;

   pmc_config u_config (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pmc_step u_step (
      .cfg             (cfg),
      .st              (state_ff),
      .switch_level    (s1_switch_ff),
      .batt_status     (s1_battery_ff),
      .safety_fault    (s1_fault_ff),
      .message_pending (s1_message_ff),
      .st_next         (state_in),
      .res             (rsp_in)
   );

   // result register frees up when empty or taken this cycle
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.mode             <= MODE_STARTUP;
         state_ff.view             <= 4'd0;
         state_ff.cursor           <= 2'd0;
         state_ff.prev_battery     <= BATT_NONE;
         state_ff.prev_switch      <= 1'b0;
         state_ff.press_armed      <= 1'b0;
         state_ff.press_left       <= '0;
         state_ff.phase_left       <= '0;
         state_ff.phase_forever    <= 1'b0;
         state_ff.refresh_left     <= '0;
         state_ff.written_contrast <= CONTRAST_OFF;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_switch_ff  <= req_switch_level;
         s1_battery_ff <= req_batt_status;
         s1_fault_ff   <= req_safety_fault;
         s1_message_ff <= req_message_pending;
      end
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_display_mode   = rsp_ff.display_mode;
   assign rsp_view_id        = rsp_ff.view_id;
   assign rsp_selected_entry = rsp_ff.selected_entry;
   assign rsp_contrast       = rsp_ff.contrast;
   assign rsp_contrast_write = rsp_ff.contrast_write;
   assign rsp_panel_on_cmd   = rsp_ff.panel_on_cmd;
   assign rsp_panel_off_cmd  = rsp_ff.panel_off_cmd;
   assign rsp_redraw         = rsp_ff.redraw;

   // a sample waiting behind a stalled result is not dropped
   a_hold_sample: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("waiting sample lost behind stalled result");

   // panel cannot be switched on and off by the same tick
   a_on_off_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.panel_on_cmd && rsp_ff.panel_off_cmd))
      else $error("panel on and off commanded together");

   // off mode always asks for zero contrast
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.display_mode == MODE_OFF) |-> rsp_ff.contrast == CONTRAST_OFF)
      else $error("off mode with non-zero contrast");

   // state moves only when a result is produced
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("controller state changed without a tick");

endmodule
`default_nettype wire

@@ test/panel_result_monitor.sv @@
// Result monitor for the panel menu controller: tracks the panel state and checks every result.
`timescale 1ns / 1ps
module panel_result_monitor (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_stall,
   input  wire                              req_switch_level,
   input  wire  [3:0]                       req_batt_status,
   input  wire                              req_safety_fault,
   input  wire                              req_message_pending,
   input  wire                              rsp_valid,
   input  wire                              rsp_stall,
   input  wire  [2:0]                       rsp_display_mode,
   input  wire  [3:0]                       rsp_view_id,
   input  wire  [1:0]                       rsp_selected_entry,
   input  wire  [7:0]                       rsp_contrast,
   input  wire                              rsp_contrast_write,
   input  wire                              rsp_panel_on_cmd,
   input  wire                              rsp_panel_off_cmd,
   input  wire                              rsp_redraw,
   input  wire                              csr_write_enable,
   input  wire  [pmc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [pmc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output int                               outstanding,
   output int                               failures
);
   import pmc_pkg::*;

   cfg_type    cfg;
   logic [2:0] panel_mode;
   logic [3:0] panel_view;
   logic [1:0] cursor;
   logic [3:0] last_batt;
   logic       last_button;
   logic       hold_timing;
   logic [15:0] hold_count;
   logic [15:0] mode_count;
   logic       mode_untimed;
   logic [15:0] redraw_count;
   logic [7:0] sent_contrast;

   result_type panel_due[$];
   int errors = 0;
   int results_seen = 0;

   assign failures = errors;

   task automatic flag_mismatch(input string what, input int want_v, input int got_v);
      errors++;
      $display("panel result %0d: %s expected %0d got %0d", results_seen, what, want_v, got_v);
   endtask

   function automatic void arm_mode_timer(input logic [15:0] ticks);
      mode_count   = ticks;
      mode_untimed = 1'b0;
   endfunction

   // One millisecond tick of the panel controller
   function automatic result_type advance_panel(input logic button, input logic [3:0] batt_in,
                                                input logic fault, input logic msg);
      logic [2:0] old_mode, next_mode;
      logic [3:0] old_view, next_view, batt;
      logic [1:0] old_cursor, next_cursor;
      logic       dim, tap, hold, show_default, changed, due, expired;
      logic       on_cmd, off_cmd, cwrite, redraw;
      logic [7:0] want_contrast;
      result_type r;

      old_mode    = panel_mode;
      old_view    = panel_view;
      old_cursor  = cursor;
      next_mode   = panel_mode;
      next_view   = panel_view;
      next_cursor = cursor;
      tap         = 1'b0;
      hold        = 1'b0;
      redraw      = 1'b0;
      off_cmd     = 1'b0;

      // saturating countdowns
      if (hold_count != 0) hold_count--;
      if (!mode_untimed && mode_count != 0) mode_count--;
      if (redraw_count != 0) redraw_count--;

      dim = (old_mode == MODE_MENU || old_mode == MODE_SCREEN) && !mode_untimed &&
            (mode_count < cfg.dim_lead_ms);

      // tap: release while the hold timer still runs
      if (button != last_button) begin
         if (!button && hold_timing && hold_count != 0) tap = 1'b1;
         hold_timing = 1'b1;
         hold_count  = cfg.switch_hold_ms;
      end
      if (hold_timing && hold_count == 0) begin
         hold        = button;
         hold_timing = 1'b0;
      end
      last_button = button;

      if (tap && (old_mode == MODE_SCREEN || old_mode == MODE_MENU)) arm_mode_timer(cfg.hold_ms);

      batt         = batt_in;
      show_default = (last_batt != batt);
      expired      = !mode_untimed && mode_count == 0;
      // splash freezes the battery view until it runs out
      if (old_mode == MODE_SPLASH && !expired) begin
         show_default = 1'b0;
         batt         = last_batt;
      end

      if (expired) begin
         if (old_mode == MODE_STARTUP) next_mode = MODE_SPLASH;
         else if (old_mode == MODE_SPLASH || old_mode == MODE_MESSAGE) show_default = 1'b1;
         else next_mode = MODE_OFF;
      end

      if (tap) begin
         if (old_mode == MODE_MENU) begin
            next_cursor = 2'((next_cursor + 1) % MENU_ENTRIES);
         end else if (old_mode == MODE_SCREEN) begin
            if (!dim) begin
               if (old_view <= 4'd2 || old_view == 4'd10) begin
                  next_mode = MODE_MENU;
                  next_view = 4'd0;
               end else if (old_view == 4'd3 || old_view == 4'd4) begin
                  next_mode = MODE_MENU;
                  next_view = 4'd1;
               end
            end else begin
               // a tap on a dimmed screen only wakes it
               dim = 1'b0;
            end
         end else if (old_mode == MODE_OFF) begin
            show_default = 1'b1;
         end
      end

      if (hold) begin
         if (old_mode == MODE_MENU) begin
            case ({old_view[0], old_cursor})
               3'b000: begin next_mode = MODE_SCREEN; next_view = 4'd0; end
               3'b001: begin next_mode = MODE_SCREEN; next_view = 4'd1; end
               3'b010: begin next_mode = MODE_SCREEN; next_view = 4'd2; end
               3'b011: begin next_mode = MODE_MENU;   next_view = 4'd1; end
               3'b100: begin next_mode = MODE_SCREEN; next_view = 4'd3; end
               3'b101: begin next_mode = MODE_SCREEN; next_view = 4'd4; end
               3'b110: begin next_mode = MODE_ACTION; next_view = 4'd0; end
               default: begin next_mode = MODE_MENU;  next_view = 4'd0; end
            endcase
         end else if (old_mode == MODE_OFF) begin
            show_default = 1'b1;
         end
      end

      if (show_default) begin
         case (batt)
            BATT_UNINIT:       next_mode = MODE_SPLASH;
            BATT_DISCONNECTED: begin next_mode = MODE_SCREEN; next_view = 4'd5; end
            BATT_SHUTDOWN:     begin next_mode = MODE_SCREEN; next_view = 4'd8; end
            BATT_INIT:         begin next_mode = MODE_SCREEN; next_view = 4'd6; end
            BATT_PF:           begin next_mode = MODE_SCREEN; next_view = 4'd7; end
            BATT_PWRCYCLE:     begin next_mode = MODE_SCREEN; next_view = 4'd9; end
            BATT_XDSG:         begin next_mode = MODE_SCREEN; next_view = 4'd10; end
            BATT_REMOVED, BATT_DSG, BATT_CHG, BATT_LATCHED: begin
               next_mode = MODE_SCREEN;
               next_view = fault ? 4'd2 : 4'd0;
            end
            default: ;
         endcase
      end

      if (msg) next_mode = MODE_MESSAGE;

      changed = (next_mode != old_mode);
      if (!changed && (next_mode == MODE_SCREEN || next_mode == MODE_MENU ||
                       next_mode == MODE_ACTION))
         changed = (next_view != old_view);

      due = (redraw_count == 0) || changed || (next_cursor != old_cursor);

      want_contrast = (next_mode == MODE_OFF) ? CONTRAST_OFF : CONTRAST_BRIGHT;
      if (!changed && dim) want_contrast = cfg.dim_level;

      on_cmd        = changed && old_mode == MODE_OFF;
      cwrite        = (sent_contrast != want_contrast);
      sent_contrast = want_contrast;

      if (due) begin
         case (next_mode)
            MODE_SPLASH: begin
               if (changed) begin
                  arm_mode_timer(cfg.splash_ms);
                  redraw = 1'b1;
               end
            end
            MODE_MESSAGE: begin
               if (changed) arm_mode_timer(cfg.message_ms);
            end
            MODE_SCREEN, MODE_ACTION: begin
               if (changed) arm_mode_timer(cfg.hold_ms);
               redraw = 1'b1;
            end
            MODE_MENU: begin
               if (changed) begin
                  next_cursor = 2'd0;
                  arm_mode_timer(cfg.hold_ms);
               end
               redraw = 1'b1;
            end
            default: begin
               if (changed) begin
                  mode_count   = 16'd0;
                  mode_untimed = 1'b1;
                  off_cmd      = 1'b1;
               end
            end
         endcase
         redraw_count = cfg.redraw_ms;
      end

      panel_mode = next_mode;
      panel_view = next_view;
      cursor     = next_cursor;
      last_batt  = batt;

      r.display_mode   = panel_mode;
      r.view_id        = (panel_mode == MODE_SCREEN || panel_mode == MODE_MENU ||
                          panel_mode == MODE_ACTION) ? panel_view : 4'd0;
      r.selected_entry = (panel_mode == MODE_MENU) ? cursor : 2'd0;
      r.contrast       = want_contrast;
      r.contrast_write = cwrite;
      r.panel_on_cmd   = on_cmd;
      r.panel_off_cmd  = off_cmd;
      r.redraw         = redraw;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         cfg.hold_ms        = HOLD_MS_RESET;
         cfg.dim_lead_ms    = DIM_LEAD_MS_RESET;
         cfg.splash_ms      = SPLASH_MS_RESET;
         cfg.message_ms     = MESSAGE_MS_RESET;
         cfg.switch_hold_ms = SWITCH_HOLD_MS_RESET;
         cfg.redraw_ms      = REDRAW_MS_RESET;
         cfg.dim_level      = DIM_LEVEL_RESET;
         panel_mode    = MODE_STARTUP;
         panel_view    = 4'd0;
         cursor        = 2'd0;
         last_batt     = BATT_NONE;
         last_button   = 1'b0;
         hold_timing   = 1'b0;
         hold_count    = 16'd0;
         mode_count    = 16'd0;
         mode_untimed  = 1'b0;
         redraw_count  = 16'd0;
         sent_contrast = CONTRAST_OFF;
         panel_due.delete();
         outstanding <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HOLD_MS:        cfg.hold_ms        = csr_write_data;
               CSR_DIM_LEAD_MS:    cfg.dim_lead_ms    = csr_write_data;
               CSR_SPLASH_MS:      cfg.splash_ms      = csr_write_data;
               CSR_MESSAGE_MS:     cfg.message_ms     = csr_write_data;
               CSR_SWITCH_HOLD_MS: cfg.switch_hold_ms = csr_write_data;
               CSR_REDRAW_MS:      cfg.redraw_ms      = csr_write_data;
               CSR_DIM_LEVEL:      cfg.dim_level      = csr_write_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (panel_due.size() == 0) begin
               flag_mismatch("result with nothing outstanding, mode", -1, rsp_display_mode);
            end else begin
               want = panel_due.pop_front();
               if (rsp_display_mode !== want.display_mode)
                  flag_mismatch("display_mode", want.display_mode, rsp_display_mode);
               if (rsp_view_id !== want.view_id)
                  flag_mismatch("view_id", want.view_id, rsp_view_id);
               if (rsp_selected_entry !== want.selected_entry)
                  flag_mismatch("selected_entry", want.selected_entry, rsp_selected_entry);
               if (rsp_contrast !== want.contrast)
                  flag_mismatch("contrast", want.contrast, rsp_contrast);
               if (rsp_contrast_write !== want.contrast_write)
                  flag_mismatch("contrast_write", want.contrast_write, rsp_contrast_write);
               if (rsp_panel_on_cmd !== want.panel_on_cmd)
                  flag_mismatch("panel_on_cmd", want.panel_on_cmd, rsp_panel_on_cmd);
               if (rsp_panel_off_cmd !== want.panel_off_cmd)
                  flag_mismatch("panel_off_cmd", want.panel_off_cmd, rsp_panel_off_cmd);
               if (rsp_redraw !== want.redraw)
                  flag_mismatch("redraw", want.redraw, rsp_redraw);
            end
         end
         if (req_valid && !req_stall)
            panel_due.push_back(advance_panel(req_switch_level, req_batt_status,
                                              req_safety_fault, req_message_pending));
         outstanding <= panel_due.size();
      end
   end

endmodule

@@ test/tb.sv @@
// Testbench top for the panel menu controller: tick stimulus, settings phases and verdict.
`timescale 1ns / 1ps
module tb;
   import pmc_pkg::*;

   // Cycles without any transfer on either channel before the run is abandoned
   localparam int WATCHDOG_LIMIT = 5000;
   // Ticks per random phase; six phases plus the directed opening give about 2000
   localparam int PHASE_TICKS    = 330;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_switch_level = 1'b0;
   logic [3:0] req_batt_status = 4'd0;
   logic       req_safety_fault = 1'b0;
   logic       req_message_pending = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_display_mode;
   logic [3:0] rsp_view_id;
   logic [1:0] rsp_selected_entry;
   logic [7:0] rsp_contrast;
   logic       rsp_contrast_write;
   logic       rsp_panel_on_cmd;
   logic       rsp_panel_off_cmd;
   logic       rsp_redraw;

   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   int outstanding;
   int failures;

   // Stimulus-side state: idle rates, the settings in force and the steady pack inputs
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      ticks_sent = 0;
   int      quiet_cycles = 0;
   cfg_type settings;
   logic [3:0] batt_now = BATT_CHG;
   logic       pack_fault = 1'b0;

   panel_menu_controller DUT (.*);

   panel_result_monitor monitor (.*);

   always #10 clock = ~clock;

   // Receiver back-pressure: a fresh coin per cycle at the current idle rate
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Watchdog: any transfer on either side restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // One tick offered on the request side, held until the transfer happens.
   // Valid is only lowered for an idle gap, never in the step it is raised again.
   task automatic send_tick(input logic button, input logic [3:0] batt, input logic fault,
                            input logic msg);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_switch_level    <= button;
      req_batt_status     <= batt;
      req_safety_fault    <= fault;
      req_message_pending <= msg;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
   endtask

   // Sender holds off until every result owed has come back (the block is then idle)
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] data);
      csr_index      <= index;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // Writes every register from the settings in force, one per clock
   task automatic load_settings;
      csr_write_enable <= 1'b1;
      put_reg(CSR_HOLD_MS,        settings.hold_ms);
      put_reg(CSR_DIM_LEAD_MS,    settings.dim_lead_ms);
      put_reg(CSR_SPLASH_MS,      settings.splash_ms);
      put_reg(CSR_MESSAGE_MS,     settings.message_ms);
      put_reg(CSR_SWITCH_HOLD_MS, settings.switch_hold_ms);
      put_reg(CSR_REDRAW_MS,      settings.redraw_ms);
      put_reg(CSR_DIM_LEVEL,      {8'h00, settings.dim_level});
      csr_write_enable <= 1'b0;
   endtask

   task automatic pick_settings(input int phase);
      int span;
      case (phase)
         0: begin
            // moderate timing, menus and dimming all reachable
            settings.hold_ms = 16'd30;  settings.dim_lead_ms = 16'd10;
            settings.splash_ms = 16'd3; settings.message_ms = 16'd4;
            settings.switch_hold_ms = 16'd4; settings.redraw_ms = 16'd5;
            settings.dim_level = 8'h10;
         end
         1: begin
            // everything at its floor: one-tick timers, no dim lead, dim to black
            settings.hold_ms = 16'd1;   settings.dim_lead_ms = 16'd0;
            settings.splash_ms = 16'd1; settings.message_ms = 16'd1;
            settings.switch_hold_ms = 16'd1; settings.redraw_ms = 16'd1;
            settings.dim_level = 8'h00;
         end
         3: begin
            // screens never time out and are always dimmed, redraw only on change
            settings.hold_ms = 16'hFFFF; settings.dim_lead_ms = 16'hFFFF;
            settings.splash_ms = 16'd2;  settings.message_ms = 16'd2;
            settings.switch_hold_ms = 16'd3; settings.redraw_ms = 16'hFFFF;
            settings.dim_level = 8'hFF;
         end
         5: begin
            // last phase: splash and message may stick for good, every press is a tap
            settings.hold_ms = 16'hFFFF;   settings.dim_lead_ms = 16'd0;
            settings.splash_ms = 16'hFFFF; settings.message_ms = 16'hFFFF;
            settings.switch_hold_ms = 16'hFFFF; settings.redraw_ms = 16'hFFFF;
            settings.dim_level = 8'hFF;
         end
         default: begin
            span = $urandom_range(4, 40);
            settings.hold_ms        = 16'(span);
            settings.dim_lead_ms    = 16'($urandom_range(0, span));
            settings.splash_ms      = 16'($urandom_range(1, 6));
            settings.message_ms     = 16'($urandom_range(1, 6));
            settings.switch_hold_ms = 16'($urandom_range(2, 6));
            settings.redraw_ms      = 16'($urandom_range(1, 12));
            settings.dim_level      = 8'($urandom_range(0, 255));
         end
      endcase
   endtask

   // A short burst of ticks that a user or the pack would plausibly produce
   task automatic play_episode;
      int pick, press_hold, tap_max, hold_len, idle_max, k;
      pick       = $urandom_range(0, 99);
      press_hold = settings.switch_hold_ms;
      tap_max    = (press_hold > 13) ? 12 : ((press_hold > 1) ? press_hold - 1 : 1);
      hold_len   = press_hold + $urandom_range(0, 3);
      if (hold_len > 60) hold_len = 60;
      idle_max   = settings.hold_ms + 3;
      if (idle_max > 60) idle_max = 60;
      if (pick < 35) begin
         // tap, then a short rest
         repeat ($urandom_range(1, tap_max)) send_tick(1'b1, batt_now, pack_fault, 1'b0);
         send_tick(1'b0, batt_now, pack_fault, 1'b0);
         repeat ($urandom_range(0, 3)) send_tick(1'b0, batt_now, pack_fault, 1'b0);
      end else if (pick < 55) begin
         // long press
         repeat (hold_len) send_tick(1'b1, batt_now, pack_fault, 1'b0);
         send_tick(1'b0, batt_now, pack_fault, 1'b0);
      end else if (pick < 70) begin
         // hands off: lets screens dim and the panel time out
         repeat ($urandom_range(1, idle_max)) send_tick(1'b0, batt_now, pack_fault, 1'b0);
      end else if (pick < 82) begin
         batt_now = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
         send_tick(1'b0, batt_now, pack_fault, 1'b0);
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 2)) send_tick(1'b0, batt_now, pack_fault, 1'b1);
      end else if (pick < 94) begin
         pack_fault = ~pack_fault;
         send_tick(1'b0, batt_now, pack_fault, 1'b0);
      end else begin
         // noise: every input random for a few ticks
         k = $urandom_range(1, 8);
         repeat (k) send_tick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int b, phase, phase_start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed opening with short timers
      send_idle_pct = 16;
      recv_idle_pct = 64;
      settings.hold_ms = 16'd20;  settings.dim_lead_ms = 16'd5;
      settings.splash_ms = 16'd2; settings.message_ms = 16'd2;
      settings.switch_hold_ms = 16'd2; settings.redraw_ms = 16'd3;
      settings.dim_level = 8'h20;
      load_settings();

      send_tick(1'b0, BATT_UNINIT, 1'b0, 1'b0);           // startup straight into splash
      repeat (3) send_tick(1'b0, BATT_CHG, 1'b0, 1'b0);   // splash runs out, charge screen
      send_tick(1'b1, BATT_CHG, 1'b0, 1'b0);              // tap: screen to main menu
      send_tick(1'b0, BATT_CHG, 1'b0, 1'b0);
      send_tick(1'b1, BATT_CHG, 1'b0, 1'b0);              // tap: cursor steps on
      send_tick(1'b0, BATT_CHG, 1'b0, 1'b0);
      repeat (3) send_tick(1'b1, BATT_CHG, 1'b0, 1'b0);   // long press opens the entry
      send_tick(1'b0, BATT_DSG, 1'b1, 1'b0);              // fault picks the pack status screen
      for (b = 1; b <= 10; b++) begin                     // remaining mapped pack states
         if (b != BATT_DSG && b != BATT_CHG) send_tick(1'b0, 4'(b), 1'b0, 1'b0);
      end
      send_tick(1'b0, 4'd11, 1'b0, 1'b0);                 // unmapped states keep the view
      send_tick(1'b0, 4'd15, 1'b1, 1'b0);
      send_tick(1'b1, 4'd15, 1'b1, 1'b1);                 // message push overrides all
      send_tick(1'b0, 4'd15, 1'b0, 1'b1);

      // Random phases: sender-light/receiver-heavy, then swapped, then no idling.
      // Each phase starts with the block drained and a fresh set of registers.
      for (phase = 0; phase < 6; phase++) begin
         drain();
         if (phase < 2) begin
            send_idle_pct = 16;
            recv_idle_pct = 64;
         end else if (phase < 4) begin
            send_idle_pct = 64;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick_settings(phase);
         load_settings();
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < PHASE_TICKS) play_episode();
      end

      drain();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/pmc_pkg.sv
rtl/pmc_config.sv
rtl/pmc_step.sv
rtl/panel_menu_controller.sv
test/panel_result_monitor.sv
test/tb.sv
